// File: rtl/stg_pkg.sv
// shared types, constants and lookup tables for the sine tone generator
package stg_pkg;

  // sizing
  localparam int TABLE_DEPTH  = 64;
  localparam int COUNTER_BITS = 16;
  localparam int PHASE_W      = $clog2(TABLE_DEPTH);
  localparam int WAVE_ENTRIES = 64;
  localparam int WAVE_IDX_W   = 6;
  localparam int SAMPLE_W     = 7;
  localparam int NOTE_COUNT   = 8;
  localparam int NOTE_SEL_W   = 3;

  typedef logic [COUNTER_BITS-1:0] count_t;
  typedef logic [PHASE_W-1:0]      phase_t;
  typedef logic [SAMPLE_W-1:0]     sample_t;
  typedef logic [NOTE_SEL_W-1:0]   note_sel_t;
  typedef logic [1:0]              kind_t;
  typedef logic [1:0]              req_t;

  // input item kinds
  localparam kind_t KIND_TICK   = 2'd0;
  localparam kind_t KIND_BYTE   = 2'd1;
  localparam kind_t KIND_BUTTON = 2'd2;

  // sensor request codes
  localparam req_t REQ_NONE = 2'd0;
  localparam req_t REQ_TEMP = 2'd1;
  localparam req_t REQ_DIST = 2'd2;

  // command characters
  localparam logic [7:0] CHAR_NOTE_FIRST = 8'h61;  // 'a'
  localparam logic [7:0] CHAR_NOTE_LAST  = 8'h68;  // 'h'
  localparam logic [7:0] CHAR_TEMP       = 8'h74;  // 't'
  localparam logic [7:0] CHAR_DIST       = 8'h70;  // 'p'

  // timer values after reset
  localparam count_t RESET_PRESCALER = COUNTER_BITS'(7);
  localparam count_t RESET_RELOAD    = COUNTER_BITS'(70);

  // prescaler and reload per note
  localparam count_t NOTE_PSC [NOTE_COUNT] = '{
    COUNTER_BITS'(15), COUNTER_BITS'(10), COUNTER_BITS'(4),  COUNTER_BITS'(11),
    COUNTER_BITS'(10), COUNTER_BITS'(3),  COUNTER_BITS'(10), COUNTER_BITS'(7)
  };
  localparam count_t NOTE_ARR [NOTE_COUNT] = '{
    COUNTER_BITS'(70), COUNTER_BITS'(91), COUNTER_BITS'(190), COUNTER_BITS'(70),
    COUNTER_BITS'(68), COUNTER_BITS'(178), COUNTER_BITS'(57), COUNTER_BITS'(70)
  };

  // 10-bit sine wave already divided by ten
  localparam sample_t SINE_DIV10 [WAVE_ENTRIES] = '{
    7'd51,  7'd56,  7'd61,  7'd66,  7'd70,  7'd75,  7'd79,  7'd83,
    7'd87,  7'd90,  7'd93,  7'd96,  7'd98,  7'd100, 7'd101, 7'd102,
    7'd102, 7'd102, 7'd101, 7'd100, 7'd98,  7'd96,  7'd93,  7'd90,
    7'd87,  7'd83,  7'd79,  7'd75,  7'd70,  7'd66,  7'd61,  7'd56,
    7'd51,  7'd46,  7'd41,  7'd36,  7'd31,  7'd27,  7'd22,  7'd18,
    7'd15,  7'd11,  7'd8,   7'd6,   7'd3,   7'd2,   7'd1,   7'd0,
    7'd0,   7'd0,   7'd1,   7'd2,   7'd3,   7'd6,   7'd8,   7'd11,
    7'd15,  7'd18,  7'd22,  7'd27,  7'd31,  7'd36,  7'd41,  7'd46
  };

  // timer control from the command decode
  typedef struct packed {
    logic      tick;
    logic      note_wr;
    note_sel_t note_sel;
  } timer_ctrl_t;

endpackage

// File: rtl/stg_timer.sv
// up-counting prescaler and reload timer producing the update event
module stg_timer
  import stg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  timer_ctrl_t ctrl,
  output logic        update
);

  count_t prescale_count, prescale_count_next;
  count_t period_count, period_count_next;
  count_t active_prescaler, active_prescaler_next;
  count_t pending_prescaler, pending_prescaler_next;
  count_t reload_limit, reload_limit_next;

  // counter stepping and note selection
  always_comb begin
    prescale_count_next    = prescale_count;
    period_count_next      = period_count;
    active_prescaler_next  = active_prescaler;
    pending_prescaler_next = pending_prescaler;
    reload_limit_next      = reload_limit;
    update                 = 1'b0;
    if (ctrl.tick) begin
      if (prescale_count == active_prescaler) begin
        prescale_count_next = '0;
        if (period_count == reload_limit) begin
          period_count_next     = '0;
          active_prescaler_next = pending_prescaler;
          update                = 1'b1;
        end else begin
          period_count_next = period_count + 1'b1;
        end
      end else begin
        prescale_count_next = prescale_count + 1'b1;
      end
    end
    // new prescaler waits for the next update, reload applies at once
    if (ctrl.note_wr) begin
      pending_prescaler_next = NOTE_PSC[ctrl.note_sel];
      reload_limit_next      = NOTE_ARR[ctrl.note_sel];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_count    <= '0;
      period_count      <= '0;
      active_prescaler  <= RESET_PRESCALER;
      pending_prescaler <= RESET_PRESCALER;
      reload_limit      <= RESET_RELOAD;
    end else begin
      prescale_count    <= prescale_count_next;
      period_count      <= period_count_next;
      active_prescaler  <= active_prescaler_next;
      pending_prescaler <= pending_prescaler_next;
      reload_limit      <= reload_limit_next;
    end
  end

endmodule

// File: rtl/stg_voice.sv
// tone enable, wavetable phase and sample lookup
module stg_voice
  import stg_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    update,
  input  logic    toggle,
  output sample_t sample,
  output logic    tone_on
);

  localparam int SCALED_W = PHASE_W + WAVE_IDX_W;

  phase_t                  phase_index, phase_index_next;
  logic                    tone_enable;
  logic                    advance;
  logic [SCALED_W-1:0]     scaled;
  logic [WAVE_IDX_W-1:0]   wave_idx;

  // map phase onto the 64-entry table
  assign scaled   = {phase_index, {WAVE_IDX_W{1'b0}}};
  assign wave_idx = WAVE_IDX_W'(scaled / TABLE_DEPTH);

  assign advance = update && tone_enable;
  assign sample  = advance ? SINE_DIV10[wave_idx] : '0;
  assign tone_on = toggle ? ~tone_enable : tone_enable;

  // phase wraps at the table depth
  always_comb begin
    phase_index_next = phase_index;
    if (advance) begin
      if (phase_index == phase_t'(TABLE_DEPTH - 1)) begin
        phase_index_next = '0;
      end else begin
        phase_index_next = phase_index + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_index <= '0;
      tone_enable <= 1'b0;
    end else begin
      phase_index <= phase_index_next;
      tone_enable <= tone_on;
    end
  end

endmodule

// File: rtl/sine_tone_generator.sv
// top level: command decode, timer, voice and result register
//
// Input stream (s_axis): one transaction per event. tuser carries the event
// kind (clock tick, received byte, button release), tdata the received byte.
// Output stream (m_axis): exactly one result transaction per input
// transaction, in order, holding the DAC sample, its valid flag, the sensor
// request code and the tone enable after the event.
// The result of a transaction accepted at one edge is registered and is
// offered on m_axis from the next cycle on. One transaction is taken per
// cycle while the receiver keeps m_axis_tready high; the timer, phase and
// lookup are combinational between the accepting edge and the result register.
// s_axis_tready is high whenever the result register is empty or is being
// taken in the same cycle, so a stalled receiver holds the result and stops
// the input after one waiting result; nothing is dropped.
// Reset clears the result register and restores the timer to prescaler 7,
// reload 70, counters zero, phase zero and tone off; s_axis_tready is high
// as soon as reset is released.
module sine_tone_generator
  import stg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [6:0] sample, [7] sample_valid,
                                      // [9:8] sensor_request, [10] tone_on, rest 0
);

  logic        accept;
  kind_t       kind;
  logic [7:0]  rx_byte;
  timer_ctrl_t timer_ctrl;
  logic        update;
  logic        toggle;
  req_t        req;
  sample_t     sample;
  logic        tone_on;

  sample_t     out_sample;
  logic        out_valid_flag;
  req_t        out_req;
  logic        out_tone;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign kind          = s_axis_tuser;
  assign rx_byte       = s_axis_tdata;

  // command decode
  always_comb begin
    timer_ctrl.tick     = accept && (kind == KIND_TICK);
    timer_ctrl.note_wr  = accept && (kind == KIND_BYTE) &&
                          (rx_byte >= CHAR_NOTE_FIRST) && (rx_byte <= CHAR_NOTE_LAST);
    timer_ctrl.note_sel = NOTE_SEL_W'(rx_byte - CHAR_NOTE_FIRST);
    toggle              = accept && (kind == KIND_BUTTON);
    req                 = REQ_NONE;
    if (kind == KIND_BYTE) begin
      if (rx_byte == CHAR_TEMP) begin
        req = REQ_TEMP;
      end else if (rx_byte == CHAR_DIST) begin
        req = REQ_DIST;
      end
    end
  end

  stg_timer u_timer (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (timer_ctrl),
    .update (update)
  );

  stg_voice u_voice (
    .clk     (clk),
    .rst     (rst),
    .update  (update),
    .toggle  (toggle),
    .sample  (sample),
    .tone_on (tone_on)
  );

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s_axis_tready) begin
      m_axis_tvalid <= s_axis_tvalid;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_sample     <= sample;
      out_valid_flag <= update;
      out_req        <= req;
      out_tone       <= tone_on;
    end
  end

  assign m_axis_tdata = {5'd0, out_tone, out_req, out_valid_flag, out_sample};

endmodule

// File: rtl/stg_checker.sv
// port-level checks on the sine tone generator, bound to the top level
module stg_checker
  import stg_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // no result offered right after reset
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result offered after reset");

  // a waiting result holds while the receiver stalls
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // input is taken whenever the result register is free
  assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty result register");

  // a nonzero sample only comes with an update, and stays in table range
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[6:0] == 7'd0 || m_axis_tdata[7]) &&
                      m_axis_tdata[6:0] <= 7'd102)
    else $error("bad sample");

  // a sensor request only follows a received byte
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser != KIND_BYTE |=>
      m_axis_tdata[9:8] == REQ_NONE)
    else $error("sensor request without a byte");

endmodule

bind sine_tone_generator stg_checker u_stg_checker (.*);

// File: test/sine_tone_generator_checker.sv
// transaction checker for the sine tone generator: predicts and compares results
`timescale 1ns / 1ps

module sine_tone_generator_checker
  import stg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] kind
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,   // [6:0] sample, [7] sample_valid,
                                      // [9:8] sensor_request, [10] tone_on
  output int          mismatch_count,
  output int          results_outstanding
);

  localparam int SINE_POINTS       = 64;
  localparam int POWER_ON_PRESCALE = 7;
  localparam int POWER_ON_RELOAD   = 70;
  localparam int MAX_REPORTS       = 100;

  // raw 10-bit sine table, scaled down by ten on lookup
  localparam logic [9:0] SINE_RAW [SINE_POINTS] = '{
    10'h200, 10'h232, 10'h263, 10'h294, 10'h2c3, 10'h2f1, 10'h31c, 10'h344,
    10'h369, 10'h38b, 10'h3a9, 10'h3c3, 10'h3d8, 10'h3e9, 10'h3f5, 10'h3fd,
    10'h3ff, 10'h3fd, 10'h3f5, 10'h3e9, 10'h3d8, 10'h3c3, 10'h3a9, 10'h38b,
    10'h369, 10'h344, 10'h31c, 10'h2f1, 10'h2c3, 10'h294, 10'h263, 10'h232,
    10'h200, 10'h1cd, 10'h19c, 10'h16b, 10'h13c, 10'h10e, 10'h0e3, 10'h0bb,
    10'h096, 10'h074, 10'h056, 10'h03c, 10'h027, 10'h016, 10'h00a, 10'h002,
    10'h000, 10'h002, 10'h00a, 10'h016, 10'h027, 10'h03c, 10'h056, 10'h074,
    10'h096, 10'h0bb, 10'h0e3, 10'h10e, 10'h13c, 10'h16b, 10'h19c, 10'h1cd
  };

  // prescaler and reload picked by the note letters a through h
  localparam int NOTE_PRESCALE [8] = '{15, 10, 4, 11, 10, 3, 10, 7};
  localparam int NOTE_RELOAD   [8] = '{70, 91, 190, 70, 68, 178, 57, 70};

  typedef struct {
    sample_t sample;
    logic    updated;
    req_t    request;
    logic    tone_on;
  } tone_result_t;

  tone_result_t dac_results [$];

  // predicted timer and voice state
  count_t prescale_cnt;
  count_t period_cnt;
  count_t active_psc;
  count_t pending_psc;
  count_t reload_val;
  int     phase_pos;
  logic   tone_en;

  tone_result_t predicted;
  tone_result_t wanted;

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_REPORTS)
      $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // one input event through the timer, command decode and voice
  task automatic step_generator(input kind_t kind, input logic [7:0] rx, output tone_result_t r);
    int idx;
    r.sample  = '0;
    r.updated = 1'b0;
    r.request = REQ_NONE;
    case (kind)
      KIND_TICK: begin
        if (prescale_cnt == active_psc) begin
          prescale_cnt = '0;
          if (period_cnt == reload_val) begin
            // update event: latch the prescaler and write the dac
            period_cnt = '0;
            active_psc = pending_psc;
            r.updated  = 1'b1;
            if (tone_en) begin
              idx      = (phase_pos * SINE_POINTS) / TABLE_DEPTH;
              r.sample = sample_t'(SINE_RAW[idx] / 10);
              phase_pos = (phase_pos + 1 >= TABLE_DEPTH) ? 0 : phase_pos + 1;
            end
          end else begin
            period_cnt = period_cnt + 1'b1;
          end
        end else begin
          prescale_cnt = prescale_cnt + 1'b1;
        end
      end
      KIND_BYTE: begin
        if (rx >= CHAR_NOTE_FIRST && rx <= CHAR_NOTE_LAST) begin
          idx         = int'(rx - CHAR_NOTE_FIRST);
          pending_psc = count_t'(NOTE_PRESCALE[idx]);
          reload_val  = count_t'(NOTE_RELOAD[idx]);
        end else if (rx == CHAR_TEMP) begin
          r.request = REQ_TEMP;
        end else if (rx == CHAR_DIST) begin
          r.request = REQ_DIST;
        end
      end
      KIND_BUTTON: begin
        tone_en = ~tone_en;
      end
      default: ;
    endcase
    r.tone_on = tone_en;
  endtask

  // compare outgoing transactions, then predict incoming ones
  always @(posedge clk) begin
    if (rst) begin
      prescale_cnt        = '0;
      period_cnt          = '0;
      active_psc          = count_t'(POWER_ON_PRESCALE);
      pending_psc         = count_t'(POWER_ON_PRESCALE);
      reload_val          = count_t'(POWER_ON_RELOAD);
      phase_pos           = 0;
      tone_en             = 1'b0;
      dac_results.delete();
      results_outstanding = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (dac_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", m_axis_tdata));
        end else begin
          wanted = dac_results.pop_front();
          if (m_axis_tdata[6:0] !== wanted.sample)
            report_mismatch($sformatf("sample %0d, want %0d",
                                      m_axis_tdata[6:0], wanted.sample));
          if (m_axis_tdata[7] !== wanted.updated)
            report_mismatch($sformatf("sample_valid %b, want %b",
                                      m_axis_tdata[7], wanted.updated));
          if (m_axis_tdata[9:8] !== wanted.request)
            report_mismatch($sformatf("sensor_request %0d, want %0d",
                                      m_axis_tdata[9:8], wanted.request));
          if (m_axis_tdata[10] !== wanted.tone_on)
            report_mismatch($sformatf("tone_on %b, want %b",
                                      m_axis_tdata[10], wanted.tone_on));
          if (m_axis_tdata[15:11] !== 5'b0)
            report_mismatch($sformatf("padding bits %b not zero", m_axis_tdata[15:11]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        step_generator(s_axis_tuser, s_axis_tdata, predicted);
        dac_results.push_back(predicted);
      end
      results_outstanding = dac_results.size();
    end
  end

  initial begin
    mismatch_count      = 0;
    results_outstanding = 0;
  end

endmodule

// File: test/sine_tone_generator_tb.sv
// stimulus and verdict for the sine tone generator
`timescale 1ns / 1ps

module sine_tone_generator_tb;
  import stg_pkg::*;

  localparam kind_t KIND_UNUSED     = 2'd3;
  localparam int    IDLE_PERCENT    = 38;
  localparam int    RANDOM_ITEMS    = 560;
  localparam int    HOLD_OFF_AT     = 1500;
  localparam int    HOLD_OFF_CYCLES = 300;
  localparam int    STALL_LIMIT     = 5000;
  localparam int    DRAIN_CYCLES    = 10;
  localparam int    NOTE_COUNT_TB   = 8;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
  logic [1:0]  s_axis_tuser;   // [1:0] kind
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [6:0] sample, [7] sample_valid,
                               // [9:8] sensor_request, [10] tone_on

  int mismatch_count;
  int results_outstanding;
  int results_taken;
  int updates_seen;
  int quiet_cycles;
  bit gaps_on;

  sine_tone_generator DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  sine_tone_generator_checker checker_i (
    .clk                 (clk),
    .rst                 (rst),
    .s_axis_tvalid       (s_axis_tvalid),
    .s_axis_tready       (s_axis_tready),
    .s_axis_tdata        (s_axis_tdata),
    .s_axis_tuser        (s_axis_tuser),
    .m_axis_tvalid       (m_axis_tvalid),
    .m_axis_tready       (m_axis_tready),
    .m_axis_tdata        (m_axis_tdata),
    .mismatch_count      (mismatch_count),
    .results_outstanding (results_outstanding)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // count results and dac updates, used to pace the stimulus
  always @(posedge clk) begin
    if (rst) begin
      results_taken <= 0;
      updates_seen  <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      results_taken <= results_taken + 1;
      if (m_axis_tdata[7])
        updates_seen <= updates_seen + 1;
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: random back-pressure plus one long hold-off
  initial begin : receiver
    int stall_left;
    bit held_off;
    stall_left    = 0;
    held_off      = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_off && results_taken >= HOLD_OFF_AT) begin
        held_off   = 1'b1;
        stall_left = HOLD_OFF_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !(gaps_on && $urandom_range(99) < IDLE_PERCENT);
      end
    end
  end

  // offer one event, called and returning at a falling edge
  task automatic send_event(input kind_t kind, input logic [7:0] rx);
    while (gaps_on && $urandom_range(99) < IDLE_PERCENT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= rx;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic send_ticks(input int count);
    repeat (count) send_event(KIND_TICK, 8'($urandom_range(255)));
  endtask

  // sender idles until every result is back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (results_outstanding != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    int         mark;
    int         retuned_at;
    int         pick;
    logic [7:0] rx;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tuser  = KIND_TICK;
    gaps_on       = 1'b0;
    repeat (11) @(negedge clk);
    rst     <= 1'b0;
    gaps_on = 1'b1;
    @(negedge clk);

    // directed: unused kind, ignored bytes, sensor requests, all notes, buttons, a tick
    send_event(KIND_UNUSED, 8'hff);
    send_event(KIND_BYTE, 8'h00);
    send_event(KIND_BYTE, 8'hff);
    send_event(KIND_BYTE, CHAR_TEMP);
    send_event(KIND_BYTE, CHAR_DIST);
    for (int n = 0; n < NOTE_COUNT_TB; n++)
      send_event(KIND_BYTE, CHAR_NOTE_FIRST + 8'(n));
    send_event(KIND_BUTTON, 8'h00);
    send_event(KIND_BUTTON, 8'haa);
    send_event(KIND_BUTTON, 8'h55);
    send_event(KIND_TICK, 8'hff);
    send_event(KIND_UNUSED, 8'h00);

    // run to the first update, then lower the reload under the period count
    mark = updates_seen;
    while (updates_seen == mark) send_ticks(1);
    send_event(KIND_BYTE, CHAR_NOTE_FIRST + 8'd5);   // reload 178
    send_ticks(560);
    send_event(KIND_BYTE, CHAR_NOTE_FIRST + 8'd6);   // reload 57, below count
    send_ticks(40);
    send_event(KIND_BYTE, CHAR_NOTE_FIRST + 8'd5);   // back to 178

    // random traffic, mostly ticks
    retuned_at = updates_seen;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      gaps_on = !(n >= 250 && n < 450);
      if (n == 150)
        drain_results();
      pick = $urandom_range(99);
      if (updates_seen != retuned_at && pick < 50) begin
        // retune just after an update, while the period count is still low
        retuned_at = updates_seen;
        send_event(KIND_BYTE, CHAR_NOTE_FIRST + 8'($urandom_range(NOTE_COUNT_TB - 1)));
      end else if (pick < 86) begin
        send_ticks(1);
      end else if (pick < 90) begin
        send_event(KIND_BUTTON, 8'($urandom_range(255)));
      end else if (pick < 98) begin
        case ($urandom_range(3))
          0:       rx = CHAR_TEMP;
          1:       rx = CHAR_DIST;
          default: rx = 8'($urandom_range(255));
        endcase
        // a stray note keeps the largest reload so the count never overtakes it
        if (rx >= CHAR_NOTE_FIRST && rx <= CHAR_NOTE_LAST)
          rx = CHAR_NOTE_FIRST + 8'd2;
        send_event(KIND_BYTE, rx);
      end else begin
        send_event(KIND_UNUSED, 8'($urandom_range(255)));
      end
    end

    // let the last results come out
    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && results_outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
